// ===== rtl/pgcs_pkg.sv =====
package pgcs_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned STEP_BITS  = 12;
  localparam int unsigned WALK_BITS  = 64;
  localparam int unsigned DIV_BITS   = (VALUE_BITS + 1) / 2 + 2;
  localparam int unsigned SQ_BITS    = VALUE_BITS + 1;
  localparam int unsigned CNT_BITS   = $clog2(VALUE_BITS + 1);

  localparam logic [WALK_BITS-1:0] TRIPLE_LIMIT = 64'h5555_5555_5555_5554;
  localparam logic [STEP_BITS-1:0] STEP_MAX     = {STEP_BITS{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_DIVIDE = 5'b00100,
    S_WALK   = 5'b01000,
    S_FLUSH  = 5'b10000
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [DIV_BITS-1:0]   divisor;
  } rem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

// ===== rtl/pgcs_if.sv =====
interface pgcs_in_if;
  logic                            valid;
  logic                            ready;
  logic [pgcs_pkg::VALUE_BITS-1:0] start_value;

  modport source (output valid, output start_value, input ready);
  modport sink (input valid, input start_value, output ready);
endinterface

interface pgcs_out_if;
  logic                           valid;
  logic                           ready;
  logic [pgcs_pkg::STEP_BITS-1:0] step_count;
  logic                           overflow;

  modport source (output valid, output step_count, output overflow, input ready);
  modport sink (input valid, input step_count, input overflow, output ready);
endinterface

// ===== rtl/pgcs_rem_unit.sv =====
module pgcs_rem_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pgcs_pkg::rem_req_t req_i,
  output pgcs_pkg::rem_rsp_t rsp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [pgcs_pkg::CNT_BITS-1:0]     cnt_q, cnt_d;
  logic [pgcs_pkg::VALUE_BITS-1:0]   sh_q, sh_d;
  logic [pgcs_pkg::DIV_BITS-1:0]     dv_q, dv_d;
  logic [pgcs_pkg::DIV_BITS-1:0]     rem_q, rem_d;
  logic [pgcs_pkg::DIV_BITS:0]       trial;
  logic [pgcs_pkg::DIV_BITS:0]       dv_ext;
  logic                              ge;

  // one restoring remainder step per cycle, msb first
  always_comb begin
    trial  = {rem_q, sh_q[pgcs_pkg::VALUE_BITS-1]};
    dv_ext = {1'b0, dv_q};
    ge     = trial >= dv_ext;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    dv_d   = dv_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = pgcs_pkg::CNT_BITS'(pgcs_pkg::VALUE_BITS);
      sh_d   = req_i.dividend;
      dv_d   = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? pgcs_pkg::DIV_BITS'(trial - dv_ext) : trial[pgcs_pkg::DIV_BITS-1:0];
      sh_d  = {sh_q[pgcs_pkg::VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - pgcs_pkg::CNT_BITS'(1);
      if (cnt_q == pgcs_pkg::CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    dv_q  <= dv_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

endmodule

// ===== rtl/prime_gated_collatz_steps.sv =====
// Prime-gated Collatz step counter.
// in_i carries one unsigned start_value per transfer; out_o returns one result
// per item: step_count (Collatz steps to reach one, saturating) and overflow
// (a 3n+1 step would have left 64 bits). Values below two, even values and
// composite values give a zero result.
// in_i.ready is high only while the sequencer is idle; one item is in work at
// a time. Values below two and even values go straight to the flush state; their
// result shows in the same cycle as in_i.ready comes back. An odd value tries
// odd divisors 3, 5, 7 and so on while (d-1)^2 < v, each through the shared
// bit-serial remainder unit. A prime then walks its trajectory at one Collatz
// step per cycle. The result sits in an output register, so the next item is
// taken while it waits. If the receiver stalls with a result still waiting, a
// new result holds in the sequencer until the register frees.
// Reset is asynchronous and active low: the sequencer goes idle and out_o.valid
// drops; no memory needs clearing.
module prime_gated_collatz_steps (
  input  logic              clk_i,
  input  logic              rst_ni,
  pgcs_in_if.sink           in_i,
  pgcs_out_if.source        out_o
);

  pgcs_pkg::state_e                  state_q, state_d;
  logic [pgcs_pkg::VALUE_BITS-1:0]   val_q, val_d;
  logic [pgcs_pkg::DIV_BITS-1:0]     d_q, d_d;
  logic [pgcs_pkg::SQ_BITS-1:0]      sq_q, sq_d;
  logic [pgcs_pkg::WALK_BITS-1:0]    n_q, n_d;
  logic [pgcs_pkg::STEP_BITS-1:0]    steps_q, steps_d;
  logic                              ovf_q, ovf_d;
  logic                              out_valid_q, out_valid_d;
  logic [pgcs_pkg::STEP_BITS-1:0]    out_steps_q, out_steps_d;
  logic                              out_ovf_q, out_ovf_d;
  logic                              in_xfer;
  logic                              sq_below;
  logic [pgcs_pkg::WALK_BITS-1:0]    triple;
  pgcs_pkg::rem_req_t                rem_req;
  pgcs_pkg::rem_rsp_t                rem_rsp;

  pgcs_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign in_i.ready = (state_q == pgcs_pkg::S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign sq_below   = sq_q < pgcs_pkg::SQ_BITS'(val_q);
  assign triple     = n_q + {n_q[pgcs_pkg::WALK_BITS-2:0], 1'b0} + pgcs_pkg::WALK_BITS'(1);

  assign rem_req.start    = (state_q == pgcs_pkg::S_CHECK) && sq_below;
  assign rem_req.dividend = val_q;
  assign rem_req.divisor  = d_q;

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    d_d         = d_q;
    sq_d        = sq_q;
    n_d         = n_q;
    steps_d     = steps_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_steps_d = out_steps_q;
    out_ovf_d   = out_ovf_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      pgcs_pkg::S_IDLE: begin
        if (in_xfer) begin
          val_d   = in_i.start_value;
          d_d     = pgcs_pkg::DIV_BITS'(3);
          sq_d    = pgcs_pkg::SQ_BITS'(4);
          steps_d = '0;
          ovf_d   = 1'b0;
          // below two or even: zero result
          if (in_i.start_value <= pgcs_pkg::VALUE_BITS'(1) || !in_i.start_value[0]) begin
            state_d = pgcs_pkg::S_FLUSH;
          end else begin
            state_d = pgcs_pkg::S_CHECK;
          end
        end
      end
      pgcs_pkg::S_CHECK: begin
        if (sq_below) begin
          state_d = pgcs_pkg::S_DIVIDE;
        end else begin
          n_d     = pgcs_pkg::WALK_BITS'(val_q);
          state_d = pgcs_pkg::S_WALK;
        end
      end
      pgcs_pkg::S_DIVIDE: begin
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            state_d = pgcs_pkg::S_FLUSH;
          end else begin
            sq_d    = sq_q + pgcs_pkg::SQ_BITS'({d_q, 2'b00});
            d_d     = d_q + pgcs_pkg::DIV_BITS'(2);
            state_d = pgcs_pkg::S_CHECK;
          end
        end
      end
      pgcs_pkg::S_WALK: begin
        if (n_q == pgcs_pkg::WALK_BITS'(1)) begin
          state_d = pgcs_pkg::S_FLUSH;
        end else if (n_q[0] && (n_q > pgcs_pkg::TRIPLE_LIMIT)) begin
          ovf_d   = 1'b1;
          state_d = pgcs_pkg::S_FLUSH;
        end else begin
          n_d = n_q[0] ? triple : {1'b0, n_q[pgcs_pkg::WALK_BITS-1:1]};
          if (steps_q != pgcs_pkg::STEP_MAX) begin
            steps_d = steps_q + pgcs_pkg::STEP_BITS'(1);
          end
        end
      end
      pgcs_pkg::S_FLUSH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_steps_d = steps_q;
          out_ovf_d   = ovf_q;
          state_d     = pgcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pgcs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pgcs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    d_q         <= d_d;
    sq_q        <= sq_d;
    n_q         <= n_d;
    steps_q     <= steps_d;
    ovf_q       <= ovf_d;
    out_steps_q <= out_steps_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.step_count = out_steps_q;
  assign out_o.overflow   = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_idle_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !rem_rsp.busy)
    else $error("remainder unit busy while idle");

  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_rsp.done |-> (state_q == pgcs_pkg::S_DIVIDE))
    else $error("remainder result outside divide phase");

  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("second item taken while one is in work");

  a_ovf_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |-> (out_o.step_count != '0))
    else $error("overflow reported with no steps");
`endif

endmodule

// ===== test/tb_prime_gated_collatz_steps.sv =====
`timescale 1ns / 100ps

module tb_prime_gated_collatz_steps;

  typedef struct packed {
    logic [pgcs_pkg::STEP_BITS-1:0] steps;
    logic                           ovf;
  } walk_res_t;

  typedef struct packed {
    logic [pgcs_pkg::VALUE_BITS-1:0] value;
    logic                            typed;
    walk_res_t                       res;
  } dir_row_t;

  localparam int unsigned NUM_DIR = 24;
  localparam int unsigned NUM_RAND = 76;

  // typed rows carry a result readable by hand, the rest go through the predictor
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{32'd0,          1'b1, '{12'd0, 1'b0}},
    '{32'd1,          1'b1, '{12'd0, 1'b0}},
    '{32'd2,          1'b1, '{12'd0, 1'b0}},
    '{32'd3,          1'b1, '{12'd7, 1'b0}},
    '{32'd4,          1'b1, '{12'd0, 1'b0}},
    '{32'd5,          1'b1, '{12'd5, 1'b0}},
    '{32'd6,          1'b1, '{12'd0, 1'b0}},
    '{32'd7,          1'b0, '{12'd0, 1'b0}},
    '{32'd9,          1'b1, '{12'd0, 1'b0}},
    '{32'd11,         1'b0, '{12'd0, 1'b0}},
    '{32'd25,         1'b1, '{12'd0, 1'b0}},
    '{32'd27,         1'b1, '{12'd0, 1'b0}},
    '{32'd49,         1'b1, '{12'd0, 1'b0}},
    '{32'd97,         1'b0, '{12'd0, 1'b0}},
    '{32'd8191,       1'b0, '{12'd0, 1'b0}},
    '{32'd65521,      1'b0, '{12'd0, 1'b0}},
    '{32'd65535,      1'b1, '{12'd0, 1'b0}},
    '{32'd65536,      1'b1, '{12'd0, 1'b0}},
    '{32'd1048573,    1'b0, '{12'd0, 1'b0}},
    '{32'h8000_0000,  1'b1, '{12'd0, 1'b0}},
    '{32'h8000_0001,  1'b1, '{12'd0, 1'b0}},
    '{32'h5555_5555,  1'b1, '{12'd0, 1'b0}},
    '{32'hFFFF_FFFE,  1'b1, '{12'd0, 1'b0}},
    '{32'hFFFF_FFFF,  1'b1, '{12'd0, 1'b0}}
  };

  logic clk;
  logic rst_n;

  pgcs_in_if  in_if ();
  pgcs_out_if out_if ();

  prime_gated_collatz_steps u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  walk_res_t   expected_q[$];
  int unsigned n_sent;
  int unsigned n_got;
  int unsigned n_err;
  int unsigned n_walks;
  int unsigned n_ovf;
  int unsigned max_steps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic walk_res_t predict_walk(logic [pgcs_pkg::VALUE_BITS-1:0] v);
    logic [pgcs_pkg::WALK_BITS-1:0] n;
    logic [pgcs_pkg::WALK_BITS-1:0] d;
    bit                             is_prime;
    walk_res_t                      r;
    n = pgcs_pkg::WALK_BITS'(v);
    r = '0;
    is_prime = (n > 1);
    for (d = 2; is_prime && (d - 1) * (d - 1) < n; d++) begin
      if (n % d == 0) is_prime = 1'b0;
    end
    if (is_prime) begin
      while (n > 1) begin
        if (n[0]) begin
          if (n > pgcs_pkg::TRIPLE_LIMIT) begin
            r.ovf = 1'b1;
            break;
          end
          n = 3 * n + 1;
        end else begin
          n = n >> 1;
        end
        if (r.steps != pgcs_pkg::STEP_MAX) r.steps++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t mismatch %s: want %0d got %0d", $time, what, want, got);
    n_err++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [pgcs_pkg::VALUE_BITS-1:0] pick_value();
    int unsigned                     k;
    logic [pgcs_pkg::VALUE_BITS-1:0] v;
    k = $urandom_range(0, 99);
    v = $urandom;
    // large values are kept even or divisible by three so the divisor search stays short
    if (k < 45) v = $urandom_range(0, 4095);
    else if (k < 65) v = $urandom_range(4096, 1 << 18);
    else if (k < 80) v[0] = 1'b0;
    else v = v - (v % 3);
    return v;
  endfunction

  task automatic feed_item(logic [pgcs_pkg::VALUE_BITS-1:0] v, int unsigned gap, bit typed,
                           walk_res_t typed_res);
    walk_res_t want;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.start_value <= v;
    do @(posedge clk); while (!in_if.ready);
    want = typed ? typed_res : predict_walk(v);
    expected_q.push_back(want);
    n_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // receiver: bursts of always ready, random stalls and long stalls
  initial begin
    int unsigned mode;
    int unsigned len;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 80);
      repeat (len) begin
        case (mode)
          0: begin
            out_if.ready <= 1'b1;
          end
          1: begin
            out_if.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_if.ready <= ($urandom_range(0, 1) == 1);
          end
          default: begin
            out_if.ready <= ($urandom_range(0, 15) == 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_result
    walk_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_got++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result step_count", 0, 32'(out_if.step_count));
      end else begin
        want = expected_q.pop_front();
        if (out_if.step_count !== want.steps)
          report_mismatch("step_count", 32'(want.steps), 32'(out_if.step_count));
        if (out_if.overflow !== want.ovf)
          report_mismatch("overflow", 32'(want.ovf), 32'(out_if.overflow));
        if (want.steps != 0) n_walks++;
        if (want.ovf) n_ovf++;
        if (want.steps > max_steps) max_steps = 32'(want.steps);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    n_sent            = 0;
    n_got             = 0;
    n_err             = 0;
    n_walks           = 0;
    n_ovf             = 0;
    max_steps         = 0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.start_value = '0;
    out_if.ready      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      feed_item(DIR_ROWS[i].value, (i % 3 == 0) ? 0 : gap_len(), DIR_ROWS[i].typed,
                DIR_ROWS[i].res);
    end
    drain_results();

    for (int i = 0; i < NUM_RAND; i++) begin
      if (i == 60) drain_results();
      feed_item(pick_value(), (i >= 30 && i < 46) ? 0 : gap_len(), 1'b0, '0);
    end
    drain_results();
    repeat (50) @(posedge clk);

    $display("sent %0d values (%0d directed), checked %0d results", n_sent, NUM_DIR, n_got);
    $display("%0d prime walks, longest %0d steps, %0d overflows", n_walks, max_steps, n_ovf);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
